// ----- src/aes_cmac_engine_assert.svh -----
// Assertion macros for the CMAC engine modules
`ifndef AES_CMAC_ENGINE_ASSERT_SVH
`define AES_CMAC_ENGINE_ASSERT_SVH

// implication checked on every edge outside reset
`define ACE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ACE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/acmac_pkg.sv -----
// Types, constants and AES helper functions for the CMAC engine
`timescale 1ns / 1ps
`default_nettype none
package acmac_pkg;

    localparam int unsigned BLK_W   = 128;
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned NUM_RND = 10;
    localparam int unsigned CNT_W   = 5;
    localparam logic [7:0]  GF_POLY = 8'h87;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [CNT_W-1:0] FULL_CNT = 5'd16;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0]      block_high;
        logic [63:0]      block_low;
        logic [CNT_W-1:0] byte_count;
        logic             final_block;
    } in_word_t;

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } out_word_t;

    // control handed from the controller to the cipher core
    typedef struct packed {
        logic start;
        logic is_subkey;
        logic is_final;
    } core_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit word, byte 0 most significant
    function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] w, input int unsigned i);
        return w[BLK_W-1-8*i -: 8];
    endfunction

    // one key schedule step: round key r-1 to round key r
    function automatic logic [BLK_W-1:0] next_rkey(input logic [BLK_W-1:0] k,
                                                   input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [BLK_W-1:0] gf_double(input logic [BLK_W-1:0] a);
        return {a[BLK_W-2:0], 1'b0} ^ {{(BLK_W-8){1'b0}}, (a[BLK_W-1] ? GF_POLY : 8'h00)};
    endfunction

endpackage
`default_nettype wire

// ----- src/acmac_lane.sv -----
// One AES column lane: SubBytes, ShiftRows, MixColumns and round key add
`timescale 1ns / 1ps
`default_nettype none
module acmac_lane
    import acmac_pkg::*;
(
    input  wire logic [BLK_W-1:0] state_in,
    input  wire logic [1:0]       col,
    input  wire logic             last_round,
    input  wire logic [31:0]      rkey_col,
    output logic [31:0]           col_out
);
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [7:0] all;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            a[r] = sbox(get_byte(state_in, 32'(r) + 32'(4 * ((32'(col) + 32'(r)) & 3))));
        end
        all = a[0] ^ a[1] ^ a[2] ^ a[3];
        for (int r = 0; r < 4; r++) begin
            m[r] = last_round ? a[r] : (a[r] ^ all ^ xtime(a[r] ^ a[(r + 1) & 3]));
        end
        col_out = {m[0], m[1], m[2], m[3]} ^ rkey_col;
    end
endmodule
`default_nettype wire

// ----- src/acmac_core.sv -----
// Iterative AES-128 core: four column lanes, one round per cycle
`timescale 1ns / 1ps
`default_nettype none
module acmac_core
    import acmac_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire core_ctl_t        ctl,
    input  wire logic [BLK_W-1:0] din,
    input  wire logic [BLK_W-1:0] key,
    output logic                  busy,
    output logic                  done,
    output logic [BLK_W-1:0]      dout
);
    logic [BLK_W-1:0] state_reg, state_next;
    logic [BLK_W-1:0] rkey_reg;
    logic [BLK_W-1:0] rkey_cur;
    logic [7:0]       rcon_reg;
    logic [3:0]       rnd_reg;
    logic             busy_reg, done_reg;
    logic [31:0]      cols [4];

    assign rkey_cur = next_rkey(rkey_reg, rcon_reg);

    for (genvar c = 0; c < 4; c++) begin : g_lane
        acmac_lane u_lane (
            .state_in  (state_reg),
            .col       (2'(c)),
            .last_round(rnd_reg == 4'(NUM_RND)),
            .rkey_col  (rkey_cur[BLK_W-1-32*c -: 32]),
            .col_out   (cols[c])
        );
    end

    // merge the lane columns back into the state word
    assign state_next = {cols[0], cols[1], cols[2], cols[3]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
            end else if (busy_reg) begin
                if (rnd_reg == 4'(NUM_RND)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                rnd_reg <= rnd_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            state_reg <= din ^ key;
            rkey_reg  <= key;
            rcon_reg  <= 8'h01;
        end else if (busy_reg) begin
            state_reg <= state_next;
            rkey_reg  <= rkey_cur;
            rcon_reg  <= xtime(rcon_reg);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign dout = state_reg;
endmodule
`default_nettype wire

// ----- src/aes_cmac_engine.sv -----
// AES-128 CMAC engine: iterative 4-lane AES core, one round per cycle plus load and handoff.
// Each accepted word is registered in ST_WAIT, then run through the core in ST_MSG; a message's first
// word first runs a subkey pass in ST_SUBK. The tag is valid once a final word's pass completes.
// A new word is accepted only in ST_IDLE, after the previous word's pass completes; the single CBC
// chain sets this, and a final word also waits while the previous tag is unaccepted.
// Synchronous active-low reset clears key, chain value and control state.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_cmac_engine_assert.svh"
module aes_cmac_engine
    import acmac_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [KEY_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_word_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_word_t             m_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUBK = 4'b0010,
        ST_MSG  = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

    state_t           st_reg, st_next;
    logic [63:0]      key_hi_reg, key_lo_reg;
    logic [BLK_W-1:0] chain_reg;
    logic [BLK_W-1:0] k1_reg, k2_reg;
    logic             subk_rdy_reg;
    in_word_t         hold_reg;
    logic             final_reg;
    logic             out_valid_reg;
    out_word_t        out_reg;

    core_ctl_t        ctl;
    logic [BLK_W-1:0] core_din, core_dout, msg, padded;
    logic             core_busy, core_done;
    logic             accept;
    logic [CNT_W-1:0] cnt;

    assign s_ready = (st_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // pad short final word with 0x80 then zeros; mask a final word with K1 (full) or K2 (padded)
    always_comb begin
        cnt = hold_reg.byte_count;
        for (int i = 0; i < 16; i++) begin
            if (i < int'(cnt)) padded[BLK_W-1-8*i -: 8] =
                get_byte({hold_reg.block_high, hold_reg.block_low}, i);
            else if (i == int'(cnt)) padded[BLK_W-1-8*i -: 8] = PAD_BYTE;
            else padded[BLK_W-1-8*i -: 8] = 8'h00;
        end
        msg = {hold_reg.block_high, hold_reg.block_low};
        if (hold_reg.final_block) begin
            if (cnt >= FULL_CNT) msg = msg ^ k1_reg;
            else msg = padded ^ k2_reg;
        end
    end

    always_comb begin
        st_next       = st_reg;
        ctl.start     = 1'b0;
        ctl.is_subkey = 1'b0;
        ctl.is_final  = hold_reg.final_block;
        core_din      = msg ^ chain_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (accept) st_next = ST_WAIT;
            end
            ST_WAIT: begin
                // hold_reg holds the accepted word here before the core is launched
                if (!subk_rdy_reg) begin
                    ctl.start     = 1'b1;
                    ctl.is_subkey = 1'b1;
                    core_din      = '0;
                    st_next       = ST_SUBK;
                end else if (!out_valid_reg || !hold_reg.final_block) begin
                    ctl.start = 1'b1;
                    st_next   = ST_MSG;
                end
            end
            ST_SUBK: begin
                if (core_done) st_next = ST_WAIT;
            end
            ST_MSG: begin
                if (core_done) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    acmac_core u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (ctl),
        .din    (core_din),
        .key    ({key_hi_reg, key_lo_reg}),
        .busy   (core_busy),
        .done   (core_done),
        .dout   (core_dout)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            key_hi_reg    <= '0;
            key_lo_reg    <= '0;
            chain_reg     <= '0;
            subk_rdy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                if (cfg_index == REG_KEY_HIGH) key_hi_reg <= cfg_data;
                if (cfg_index == REG_KEY_LOW)  key_lo_reg <= cfg_data;
            end
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (ctl.start) final_reg <= ctl.is_final;
            if (core_done && st_reg == ST_SUBK) begin
                subk_rdy_reg <= 1'b1;
            end else if (core_done && st_reg == ST_MSG) begin
                if (final_reg) begin
                    chain_reg     <= '0;
                    subk_rdy_reg  <= 1'b0;
                    out_valid_reg <= 1'b1;
                end else begin
                    chain_reg <= core_dout;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) hold_reg <= s_data;
        if (core_done && st_reg == ST_SUBK) begin
            k1_reg <= gf_double(core_dout);
            k2_reg <= gf_double(gf_double(core_dout));
        end
        if (core_done && st_reg == ST_MSG && final_reg) begin
            out_reg <= core_dout;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `ACE_ASSERT_IMPL(a_start_idle_core, aclk, aresetn, ctl.start, !core_busy)
    `ACE_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, core_busy, !s_ready)
    `ACE_ASSERT_NEXT(a_done_clears_busy, aclk, aresetn, core_done, !core_busy)
    `ACE_ASSERT_IMPL(a_msg_needs_subkeys, aclk, aresetn,
        ctl.start && !ctl.is_subkey, subk_rdy_reg)
endmodule
`default_nettype wire
